/* hdl/ccgs_pkg.sv */
// Shared types and constants for the cave generation step unit.
package ccgs_pkg;

   localparam int ROW_BITS    = 64;
   localparam int WIDTH_BITS  = 7;
   localparam int MAX_WIDTH   = 64;
   localparam int QUEUE_DEPTH = 2;

   // wall threshold for a wall cell; a floor cell needs one more
   localparam int WALL_KEEP = 4;

   localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(64);

   typedef struct packed {
      logic [ROW_BITS-1:0] row_cells;
      logic                last_row;
   } req_word_type;

   typedef struct packed {
      logic [ROW_BITS-1:0] out_row_cells;
      logic                frame_end;
   } rsp_word_type;

   // one accepted row with the row context it needs
   typedef struct packed {
      logic [ROW_BITS-1:0] above;
      logic [ROW_BITS-1:0] middle;
      logic [ROW_BITS-1:0] below;
      logic                has_first;
      logic                last;
   } job_type;

   // queue head toward the back end
   typedef struct packed {
      logic    valid;
      job_type job;
   } job_head_type;

endpackage

/* hdl/cellular_cave_generation_step_unit.sv */
// Cave generation step unit: rows in, one generation of the 4-5 rule out.
// Result words are registered; an accepted row word passes through the job queue first.
// Throughput: one row word per cycle while the queue has room; a last row holds the rule
//   unit for a second step, since it releases the closing row as a second result word.
// Reset (synchronous): queue and output empty, row window at wall, width 64.
module cellular_cave_generation_step_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [ccgs_pkg::WIDTH_BITS-1:0]   csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  ccgs_pkg::req_word_type            req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ccgs_pkg::rsp_word_type            rsp_word
);
   import ccgs_pkg::*;

   logic         queue_full;
   logic         push;
   job_type      push_job;
   logic         pop;
   job_head_type head;

   ccgs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   ccgs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .head     (head)
   );

   ccgs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word)
   );

endmodule

/* hdl/ccgs_front.sv */
// Front end: accepts rows, keeps the two previous rows, emits jobs.
module ccgs_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ccgs_pkg::req_word_type req_word,
   input  logic                  queue_full,
   output logic                  push,
   output ccgs_pkg::job_type     push_job
);
   import ccgs_pkg::*;

   logic [ROW_BITS-1:0] older_row_ff, older_row_in;
   logic [ROW_BITS-1:0] middle_row_ff;
   logic                middle_valid_ff, middle_valid_in;

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   // job carries the row window as it stands before this word
   always_comb begin
      push_job.above     = older_row_ff;
      push_job.middle    = middle_row_ff;
      push_job.below     = req_word.row_cells;
      push_job.has_first = middle_valid_ff;
      push_job.last      = req_word.last_row;
   end

   // row window update; last row reopens a fresh grid
   always_comb begin
      older_row_in    = older_row_ff;
      middle_valid_in = middle_valid_ff;
      if (req_word.last_row) begin
         older_row_in    = '1;
         middle_valid_in = 1'b0;
      end else begin
         if (middle_valid_ff) begin
            older_row_in = middle_row_ff;
         end
         middle_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         older_row_ff    <= '1;
         middle_valid_ff <= 1'b0;
      end else if (push) begin
         older_row_ff    <= older_row_in;
         middle_valid_ff <= middle_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         middle_row_ff <= req_word.row_cells;
      end
   end

endmodule

/* hdl/ccgs_queue.sv */
// Short job queue between front and back ends.
module ccgs_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ccgs_pkg::job_type      push_job,
   output logic                   full,
   input  logic                   pop,
   output ccgs_pkg::job_head_type head
);
   import ccgs_pkg::*;

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(QUEUE_DEPTH);
   localparam logic [PTR_BITS-1:0] LAST_PTR  = PTR_BITS'(QUEUE_DEPTH - 1);

   job_type             entries_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_pop;

   assign full       = (count_ff == DEPTH_CNT);
   assign head.valid = (count_ff != '0);
   assign head.job   = entries_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   // pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* hdl/ccgs_back.sv */
// Back end: applies the cave rule to a row window and registers the result.
module ccgs_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [ccgs_pkg::WIDTH_BITS-1:0]     csr_wr_data,
   input  ccgs_pkg::job_head_type              head,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ccgs_pkg::rsp_word_type              rsp_word
);
   import ccgs_pkg::*;

   localparam logic [WIDTH_BITS-1:0] MAX_W = WIDTH_BITS'(MAX_WIDTH);

   logic [WIDTH_BITS-1:0] grid_width_ff;
   logic                  phase_ff, phase_in;
   logic                  rsp_valid_ff;
   rsp_word_type          rsp_word_ff;

   logic [WIDTH_BITS-1:0] width_used;
   logic [ROW_BITS-1:0]   lane_mask;
   logic [ROW_BITS-1:0]   sel_above, sel_middle, sel_below;
   logic                  sel_end, emit, retire, out_free, step;
   logic [ROW_BITS-1:0]   next_row;

   // one generation over a three-row window
   function automatic logic [ROW_BITS-1:0] next_gen(
      input logic [ROW_BITS-1:0] above,
      input logic [ROW_BITS-1:0] mid,
      input logic [ROW_BITS-1:0] below,
      input logic [ROW_BITS-1:0] mask
   );
      logic [ROW_BITS-1:0] a, m, b, al, ar, ml, mr, bl, br, res;
      logic [3:0]          cnt;
      a   = above | ~mask;
      m   = mid   | ~mask;
      b   = below | ~mask;
      al  = {a[ROW_BITS-2:0], 1'b1};
      ar  = {1'b1, a[ROW_BITS-1:1]};
      ml  = {m[ROW_BITS-2:0], 1'b1};
      mr  = {1'b1, m[ROW_BITS-1:1]};
      bl  = {b[ROW_BITS-2:0], 1'b1};
      br  = {1'b1, b[ROW_BITS-1:1]};
      res = '0;
      for (int k = 0; k < ROW_BITS; k++) begin
         cnt = 4'(al[k]) + 4'(a[k]) + 4'(ar[k]) + 4'(ml[k])
             + 4'(mr[k]) + 4'(bl[k]) + 4'(b[k]) + 4'(br[k]);
         if (m[k]) begin
            res[k] = (cnt >= 4'(WALL_KEEP));
         end else begin
            res[k] = (cnt >= 4'(WALL_KEEP + 1));
         end
      end
      return res & mask;
   endfunction

   // lanes in use, width clamped to the row size
   always_comb begin
      width_used = (grid_width_ff > MAX_W) ? MAX_W : grid_width_ff;
      for (int k = 0; k < ROW_BITS; k++) begin
         lane_mask[k] = (WIDTH_BITS'(k) < width_used);
      end
   end

   // pick the window: inner row first, then the closing row on a last word; a grid's first row alone emits nothing
   always_comb begin
      sel_above  = head.job.above;
      sel_middle = head.job.middle;
      sel_below  = head.job.below;
      sel_end    = 1'b0;
      emit       = 1'b0;
      retire     = 1'b1;
      phase_in   = 1'b0;
      if (phase_ff) begin
         sel_above  = head.job.middle;
         sel_middle = head.job.below;
         sel_below  = '1;
         sel_end    = 1'b1;
         emit       = 1'b1;
      end else if (head.job.has_first) begin
         emit     = 1'b1;
         retire   = !head.job.last;
         phase_in = head.job.last;
      end else if (head.job.last) begin
         sel_middle = head.job.below;
         sel_below  = '1;
         sel_end    = 1'b1;
         emit       = 1'b1;
      end
   end

   assign next_row = next_gen(sel_above, sel_middle, sel_below, lane_mask);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign step     = head.valid && (!emit || out_free);
   assign pop      = step && retire;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff <= WIDTH_RESET;
         phase_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            grid_width_ff <= csr_wr_data;
         end
         if (step) begin
            phase_ff <= phase_in;
         end
         if (step && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (step && emit) begin
         rsp_word_ff.out_row_cells <= next_row;
         rsp_word_ff.frame_end     <= sel_end;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
